// ===== rtl/pdw_pkg.sv =====
// ----------------------------------------------------------------------------
// pdw_pkg: shared definitions for the phase distortion warp
// Widths, fixed-point constants, mode codes and the sideband structures
// that travel beside the two pipelined dividers.
// ----------------------------------------------------------------------------
package pdw_pkg;

    localparam int POSITION_INT_BITS  = 16;
    localparam int POSITION_FRAC_BITS = 16;
    localparam int INNER_FRAC_BITS    = 24;

    localparam int POS_W      = POSITION_INT_BITS + POSITION_FRAC_BITS;
    localparam int FB         = INNER_FRAC_BITS;
    localparam int MODE_W     = 3;
    localparam int AMT_W      = 16;
    localparam int AMT_FRAC   = 14;
    localparam int DIV_NW     = POS_W + FB;
    localparam int DIV_DW     = POS_W;
    localparam int DIV_STAGES = DIV_NW;
    localparam int PC_W       = FB + 3;
    localparam int P4_W       = FB + 17;
    localparam int LG_W       = FB + 6;
    localparam int LZ_W       = 5;
    localparam int E14_W      = 18;
    localparam int Y_W        = FB + 10;
    localparam int RES_W      = 2 * FB + 8;
    localparam int MUL_W      = (P4_W + 1) + (E14_W + 1);
    localparam int LATENCY    = 2 * DIV_STAGES + 7;

    localparam logic signed [PC_W-1:0]  F_ONE   = PC_W'(64'd1 << FB);
    localparam logic signed [PC_W-1:0]  F_HALF  = PC_W'(64'd1 << (FB - 1));
    localparam logic signed [RES_W-1:0] RES_ONE = RES_W'(64'd1 << FB);
    localparam logic signed [FB:0]      K499    =
        (FB + 1)'(((64'd499 << FB) + 64'd500) / 64'd1000);
    localparam logic signed [AMT_W:0]   AMT_ONE = (AMT_W + 1)'(64'd1 << AMT_FRAC);
    localparam logic [DIV_NW-1:0]       PC_LIM  = DIV_NW'(64'd1 << (FB + 1));
    localparam logic [DIV_NW-1:0]       P4_LIM  = DIV_NW'(64'd1 << (FB + 15));
    localparam logic [DIV_NW-1:0]       POW_NUM = DIV_NW'(64'd1 << (2 * AMT_FRAC));
    localparam logic [Y_W:0]            Y_FMASK = (Y_W + 1)'((64'd1 << FB) - 64'd1);

    typedef enum logic [MODE_W-1:0] {
        MODE_PASS     = 3'd0,
        MODE_PULSE    = 3'd1,
        MODE_SQUARE   = 3'd2,
        MODE_TRIANGLE = 3'd3,
        MODE_DSINE    = 3'd4,
        MODE_SAWTRI   = 3'd5,
        MODE_POW4     = 3'd6,
        MODE_POW8     = 3'd7
    } t_mode;

    typedef struct packed {
        logic                    bypass;
        t_mode                   mode;
        logic [POS_W-1:0]        pos;
        logic [POS_W-1:0]        ws;
        logic [POS_W-1:0]        len;
        logic                    neg;
        logic signed [AMT_W:0]   d;
        logic signed [FB-1:0]    hd;
    } t_side;

    typedef struct packed {
        logic                    bypass;
        t_mode                   mode;
        logic [POS_W-1:0]        pos;
        logic [POS_W-1:0]        ws;
        logic [POS_W-1:0]        len;
        logic                    pc_pos;
        logic                    negq;
        logic signed [PC_W-1:0]  base;
        logic signed [P4_W-1:0]  p4;
        logic signed [P4_W:0]    diff4;
        logic [AMT_W-2:0]        amt;
        logic                    dneg;
        logic [E14_W-1:0]        e14;
        logic signed [LG_W-1:0]  lg;
    } t_mid;

endpackage

// ===== rtl/phase_distortion_warp.sv =====
// ----------------------------------------------------------------------------
// phase_distortion_warp: phase distortion warp of an oscillator position
// The block accepts a transaction whenever start is high (busy is never
// asserted) and returns exactly one result per transaction, in order, on
// o_valid for a single cycle, once it has passed through the whole pipeline.
// There is no flow control on the result side: the receiver cannot stall
// and must take each result in the cycle that o_valid is high.
// One transaction can enter on every clock cycle. The latency is set by
// two pipelined dividers of 56 stages each, one quotient bit per stage,
// that normalize the phase into the window and bend it, plus seven stages
// of setup and finishing logic. Mode 0, or an empty or inverted window,
// returns the position unchanged with the same latency.
// ----------------------------------------------------------------------------
module phase_distortion_warp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [pdw_pkg::MODE_W-1:0]          i_mode,
    input  logic [pdw_pkg::POS_W-1:0]           i_position,
    input  logic signed [pdw_pkg::AMT_W-1:0]    i_amount,
    input  logic [pdw_pkg::POS_W-1:0]           i_window_start,
    input  logic [pdw_pkg::POS_W-1:0]           i_window_end,
    output logic                                o_valid,
    output logic [pdw_pkg::POS_W-1:0]           o_warped_position
);

    logic [pdw_pkg::POS_W-1:0]                  mag;
    logic signed [pdw_pkg::AMT_W:0]             d_ext;
    logic signed [pdw_pkg::AMT_W:0]             d_clamp;
    logic signed [pdw_pkg::FB+pdw_pkg::AMT_W+1:0] hd_prod;
    pdw_pkg::t_side                             n_a_side;
    logic [pdw_pkg::DIV_NW-1:0]                 n_a_num;

    logic                                       r_a_vld;
    pdw_pkg::t_side                             r_a_side;
    logic [pdw_pkg::DIV_NW-1:0]                 r_a_num;
    logic [pdw_pkg::DIV_DW-1:0]                 r_a_den;

    pdw_pkg::t_side                             r_sb1 [pdw_pkg::DIV_STAGES];
    pdw_pkg::t_mid                              r_sb2 [pdw_pkg::DIV_STAGES];

    logic                                       div1_vld;
    logic [pdw_pkg::DIV_NW-1:0]                 div1_quot;
    logic                                       prep_vld;
    pdw_pkg::t_mid                              prep_mid;
    logic [pdw_pkg::DIV_NW-1:0]                 prep_num;
    logic [pdw_pkg::DIV_DW-1:0]                 prep_den;
    logic                                       div2_vld;
    logic [pdw_pkg::DIV_NW-1:0]                 div2_quot;

    assign busy = 1'b0;

    always_comb begin
        n_a_side.bypass = (i_mode == pdw_pkg::MODE_PASS) || (i_window_end <= i_window_start);
        n_a_side.mode   = pdw_pkg::t_mode'(i_mode);
        n_a_side.pos    = i_position;
        n_a_side.ws     = i_window_start;
        n_a_side.len    = i_window_end - i_window_start;
        n_a_side.neg    = i_position < i_window_start;
        mag = n_a_side.neg ? i_window_start - i_position : i_position - i_window_start;
        d_ext = $signed({i_amount[pdw_pkg::AMT_W-1], i_amount});
        if (d_ext > pdw_pkg::AMT_ONE) begin
            d_clamp = pdw_pkg::AMT_ONE;
        end else if (d_ext < -pdw_pkg::AMT_ONE) begin
            d_clamp = -pdw_pkg::AMT_ONE;
        end else begin
            d_clamp = d_ext;
        end
        n_a_side.d  = d_clamp;
        hd_prod     = (pdw_pkg::FB+pdw_pkg::AMT_W+2)'(pdw_pkg::K499)
                    * (pdw_pkg::FB+pdw_pkg::AMT_W+2)'(d_clamp);
        n_a_side.hd = hd_prod[pdw_pkg::FB+pdw_pkg::AMT_FRAC-1:pdw_pkg::AMT_FRAC];
        n_a_num     = {mag, {pdw_pkg::FB{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_side <= n_a_side;
        r_a_num  <= n_a_num;
        r_a_den  <= n_a_side.len;
    end

    pdw_div u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_vld),
        .i_num   (r_a_num),
        .i_den   (r_a_den),
        .o_valid (div1_vld),
        .o_quot  (div1_quot)
    );

    always_ff @(posedge i_clk) begin
        r_sb1[0] <= r_a_side;
        r_sb2[0] <= prep_mid;
        for (int i = 1; i < pdw_pkg::DIV_STAGES; i++) begin
            r_sb1[i] <= r_sb1[i-1];
            r_sb2[i] <= r_sb2[i-1];
        end
    end

    pdw_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div1_vld),
        .i_side  (r_sb1[pdw_pkg::DIV_STAGES-1]),
        .i_quot  (div1_quot),
        .o_valid (prep_vld),
        .o_mid   (prep_mid),
        .o_num   (prep_num),
        .o_den   (prep_den)
    );

    pdw_div u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prep_vld),
        .i_num   (prep_num),
        .i_den   (prep_den),
        .o_valid (div2_vld),
        .o_quot  (div2_quot)
    );

    pdw_post u_post (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (div2_vld),
        .i_mid             (r_sb2[pdw_pkg::DIV_STAGES-1]),
        .i_quot            (div2_quot),
        .o_valid           (o_valid),
        .o_warped_position (o_warped_position)
    );

`ifndef SYNTH
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, pdw_pkg::LATENCY))
        else $error("result without a matching transaction");

    a_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past((i_mode == pdw_pkg::MODE_PASS) ||
                          (i_window_end <= i_window_start), pdw_pkg::LATENCY))
        |-> (o_warped_position == $past(i_position, pdw_pkg::LATENCY)))
        else $error("pass-through transaction changed the position");

    a_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past((i_mode != pdw_pkg::MODE_PASS) &&
                          (i_window_end > i_window_start), pdw_pkg::LATENCY))
        |-> ((o_warped_position >= $past(i_window_start, pdw_pkg::LATENCY)) &&
             (o_warped_position <= $past(i_window_end, pdw_pkg::LATENCY))))
        else $error("warped position outside the window");
`endif

endmodule

// ===== rtl/pdw_div.sv =====
// ----------------------------------------------------------------------------
// pdw_div: pipelined unsigned restoring divider
// One quotient bit per register stage; a new transaction may enter on
// every clock cycle.
// ----------------------------------------------------------------------------
module pdw_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [pdw_pkg::DIV_NW-1:0]  i_num,
    input  logic [pdw_pkg::DIV_DW-1:0]  i_den,
    output logic                        o_valid,
    output logic [pdw_pkg::DIV_NW-1:0]  o_quot
);

    logic [pdw_pkg::DIV_DW-1:0] r_rem [pdw_pkg::DIV_STAGES-1];
    logic [pdw_pkg::DIV_DW-1:0] r_den [pdw_pkg::DIV_STAGES-1];
    logic [pdw_pkg::DIV_NW-1:0] r_nq  [pdw_pkg::DIV_STAGES];
    logic                       r_vld [pdw_pkg::DIV_STAGES];

    for (genvar g = 0; g < pdw_pkg::DIV_STAGES; g++) begin : g_stage
        logic [pdw_pkg::DIV_DW-1:0] rem_in;
        logic [pdw_pkg::DIV_DW-1:0] den_in;
        logic [pdw_pkg::DIV_NW-1:0] nq_in;
        logic                       vld_in;
        logic [pdw_pkg::DIV_DW:0]   trial;
        logic                       ge;
        logic [pdw_pkg::DIV_DW-1:0] n_rem;
        logic [pdw_pkg::DIV_NW-1:0] n_nq;

        if (g == 0) begin : g_first
            assign rem_in = '0;
            assign den_in = i_den;
            assign nq_in  = i_num;
            assign vld_in = i_valid;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign den_in = r_den[g-1];
            assign nq_in  = r_nq[g-1];
            assign vld_in = r_vld[g-1];
        end

        always_comb begin
            trial = {rem_in, nq_in[pdw_pkg::DIV_NW-1]};
            ge    = trial >= {1'b0, den_in};
            n_rem = ge ? pdw_pkg::DIV_DW'(trial - {1'b0, den_in})
                       : trial[pdw_pkg::DIV_DW-1:0];
            n_nq  = {nq_in[pdw_pkg::DIV_NW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_nq[g] <= n_nq;
        end

        if (g < pdw_pkg::DIV_STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[g] <= n_rem;
                r_den[g] <= den_in;
            end
        end
    end

    assign o_valid = r_vld[pdw_pkg::DIV_STAGES-1];
    assign o_quot  = r_nq[pdw_pkg::DIV_STAGES-1];

endmodule

// ===== rtl/pdw_prep.sv =====
// ----------------------------------------------------------------------------
// pdw_prep: curve setup between the two dividers
// Saturates the relative phase, builds the double sine target, the
// logarithm for the power curves and the operands of the second division.
// ----------------------------------------------------------------------------
module pdw_prep (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  pdw_pkg::t_side              i_side,
    input  logic [pdw_pkg::DIV_NW-1:0]  i_quot,
    output logic                        o_valid,
    output pdw_pkg::t_mid               o_mid,
    output logic [pdw_pkg::DIV_NW-1:0]  o_num,
    output logic [pdw_pkg::DIV_DW-1:0]  o_den
);

    logic [pdw_pkg::FB+1:0]             pc_mag;
    logic [pdw_pkg::FB+15:0]            p4_mag;
    logic [pdw_pkg::FB-1:0]             fr;
    logic signed [pdw_pkg::PC_W-1:0]    dbl;
    logic signed [pdw_pkg::PC_W-1:0]    n_p1_pc;
    logic signed [pdw_pkg::P4_W-1:0]    n_p1_p4;
    logic signed [pdw_pkg::PC_W-1:0]    n_p1_tgt;

    logic                               r_p1_vld;
    pdw_pkg::t_side                     r_p1_side;
    logic signed [pdw_pkg::PC_W-1:0]    r_p1_pc;
    logic signed [pdw_pkg::P4_W-1:0]    r_p1_p4;
    logic signed [pdw_pkg::PC_W-1:0]    r_p1_tgt;

    logic [pdw_pkg::AMT_W:0]            dabs;
    logic [pdw_pkg::FB+1:0]             lx;
    logic [pdw_pkg::LZ_W-1:0]           lz;
    logic [pdw_pkg::FB+1:0]             xs;
    logic [pdw_pkg::LG_W-pdw_pkg::FB-1:0] kk;
    logic signed [pdw_pkg::PC_W-1:0]    hd_ext;
    logic signed [pdw_pkg::PC_W-1:0]    bp;
    logic signed [pdw_pkg::PC_W-1:0]    nsv;
    logic signed [pdw_pkg::PC_W-1:0]    dsv;
    logic [pdw_pkg::PC_W-1:0]           nabs;
    logic                               sub;
    logic                               is_pow;
    pdw_pkg::t_mid                      n_mid;
    logic [pdw_pkg::DIV_NW-1:0]         n_num;
    logic [pdw_pkg::DIV_DW-1:0]         n_den;

    logic                               r_p2_vld;
    pdw_pkg::t_mid                      r_p2_mid;
    logic [pdw_pkg::DIV_NW-1:0]         r_p2_num;
    logic [pdw_pkg::DIV_DW-1:0]         r_p2_den;

    always_comb begin
        pc_mag = (i_quot > pdw_pkg::PC_LIM) ? pdw_pkg::PC_LIM[pdw_pkg::FB+1:0]
                                            : i_quot[pdw_pkg::FB+1:0];
        p4_mag = (i_quot > pdw_pkg::P4_LIM) ? pdw_pkg::P4_LIM[pdw_pkg::FB+15:0]
                                            : i_quot[pdw_pkg::FB+15:0];
        fr     = {i_quot[pdw_pkg::FB-2:0], 1'b0};
        n_p1_pc = i_side.neg ? -$signed({1'b0, pc_mag}) : $signed({1'b0, pc_mag});
        n_p1_p4 = i_side.neg ? -$signed({1'b0, p4_mag}) : $signed({1'b0, p4_mag});
        dbl = $signed({{(pdw_pkg::PC_W-pdw_pkg::FB){1'b0}}, fr});
        if (i_side.neg) begin
            dbl = -dbl;
        end
        n_p1_tgt = i_side.d[pdw_pkg::AMT_W] ? pdw_pkg::F_ONE - dbl : dbl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else begin
            r_p1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_side <= i_side;
        r_p1_pc   <= n_p1_pc;
        r_p1_p4   <= n_p1_p4;
        r_p1_tgt  <= n_p1_tgt;
    end

    always_comb begin
        n_mid.bypass = r_p1_side.bypass;
        n_mid.mode   = r_p1_side.mode;
        n_mid.pos    = r_p1_side.pos;
        n_mid.ws     = r_p1_side.ws;
        n_mid.len    = r_p1_side.len;
        n_mid.pc_pos = !r_p1_pc[pdw_pkg::PC_W-1] && (r_p1_pc != '0);
        n_mid.p4     = r_p1_p4;
        n_mid.diff4  = $signed({{(pdw_pkg::P4_W+1-pdw_pkg::PC_W){r_p1_tgt[pdw_pkg::PC_W-1]}},
                                r_p1_tgt})
                     - $signed({r_p1_p4[pdw_pkg::P4_W-1], r_p1_p4});
        dabs         = r_p1_side.d[pdw_pkg::AMT_W] ? -r_p1_side.d : r_p1_side.d;
        n_mid.amt    = dabs[pdw_pkg::AMT_W-2:0];
        n_mid.dneg   = r_p1_side.d[pdw_pkg::AMT_W];
        n_mid.e14    = pdw_pkg::E14_W'(pdw_pkg::AMT_ONE)
                     + ((r_p1_side.mode == pdw_pkg::MODE_POW4)
                        ? pdw_pkg::E14_W'({dabs[pdw_pkg::AMT_W-2:0], 2'b00})
                        : pdw_pkg::E14_W'({dabs[pdw_pkg::AMT_W-2:0], 3'b000}));

        lx = r_p1_pc[pdw_pkg::FB+1:0];
        lz = '0;
        for (int i = 0; i < pdw_pkg::FB + 2; i++) begin
            if (lx[i]) begin
                lz = pdw_pkg::LZ_W'(pdw_pkg::FB + 1 - i);
            end
        end
        xs       = lx << lz;
        kk       = (pdw_pkg::LG_W - pdw_pkg::FB)'(1) - {1'b0, lz};
        n_mid.lg = $signed({kk, xs[pdw_pkg::FB:1]});

        hd_ext = $signed({{(pdw_pkg::PC_W-pdw_pkg::FB){r_p1_side.hd[pdw_pkg::FB-1]}},
                          r_p1_side.hd});
        bp     = pdw_pkg::F_HALF + hd_ext;
        nsv    = '0;
        dsv    = pdw_pkg::PC_W'(1);
        sub    = 1'b0;
        is_pow = 1'b0;
        n_mid.base = '0;
        unique case (r_p1_side.mode) inside
            pdw_pkg::MODE_PULSE: begin
                if (r_p1_pc < bp) begin
                    nsv = r_p1_pc;
                    dsv = bp;
                end else begin
                    nsv = r_p1_pc - bp;
                    dsv = pdw_pkg::F_ONE - bp;
                    n_mid.base = pdw_pkg::F_HALF;
                end
            end
            pdw_pkg::MODE_SQUARE: begin
                dsv = pdw_pkg::F_HALF - hd_ext;
                if (r_p1_pc < pdw_pkg::F_HALF) begin
                    nsv = r_p1_pc;
                end else begin
                    nsv = pdw_pkg::F_ONE - r_p1_pc;
                    sub = 1'b1;
                    n_mid.base = pdw_pkg::F_ONE;
                end
            end
            pdw_pkg::MODE_TRIANGLE: begin
                dsv = pdw_pkg::F_HALF - hd_ext;
                if (r_p1_pc < pdw_pkg::F_HALF) begin
                    nsv = r_p1_pc;
                end else begin
                    nsv = r_p1_pc - pdw_pkg::F_HALF;
                    n_mid.base = pdw_pkg::F_HALF;
                end
            end
            pdw_pkg::MODE_SAWTRI: begin
                if (r_p1_pc < pdw_pkg::F_HALF) begin
                    nsv = r_p1_pc;
                    dsv = pdw_pkg::F_HALF - hd_ext;
                end else begin
                    nsv = r_p1_pc - pdw_pkg::F_HALF;
                    dsv = pdw_pkg::F_HALF + hd_ext;
                    n_mid.base = pdw_pkg::F_HALF;
                end
            end
            pdw_pkg::MODE_POW4, pdw_pkg::MODE_POW8: begin
                is_pow = 1'b1;
            end
            default: begin
                nsv = '0;
            end
        endcase
        nabs       = nsv[pdw_pkg::PC_W-1] ? -nsv : nsv;
        n_mid.negq = nsv[pdw_pkg::PC_W-1] ^ sub;
        if (is_pow) begin
            n_num = pdw_pkg::POW_NUM + pdw_pkg::DIV_NW'(n_mid.e14 >> 1);
            n_den = pdw_pkg::DIV_DW'(n_mid.e14);
        end else begin
            n_num = pdw_pkg::DIV_NW'(nabs) << (pdw_pkg::FB - 1);
            n_den = pdw_pkg::DIV_DW'(dsv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else begin
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2_mid <= n_mid;
        r_p2_num <= n_num;
        r_p2_den <= n_den;
    end

    assign o_valid = r_p2_vld;
    assign o_mid   = r_p2_mid;
    assign o_num   = r_p2_num;
    assign o_den   = r_p2_den;

endmodule

// ===== rtl/pdw_post.sv =====
// ----------------------------------------------------------------------------
// pdw_post: curve finish and window mapping
// Applies the quotient, the double sine blend or the exponential of the
// power curves, clamps to the unit range and maps back into the window.
// ----------------------------------------------------------------------------
module pdw_post (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  pdw_pkg::t_mid               i_mid,
    input  logic [pdw_pkg::DIV_NW-1:0]  i_quot,
    output logic                        o_valid,
    output logic [pdw_pkg::POS_W-1:0]   o_warped_position
);

    logic signed [pdw_pkg::RES_W-1:0]   qv;
    logic signed [pdw_pkg::RES_W-1:0]   n_q1_res;
    logic [pdw_pkg::E14_W-1:0]          b14;
    logic signed [pdw_pkg::P4_W:0]      op_a;
    logic signed [pdw_pkg::E14_W:0]     op_b;
    logic signed [pdw_pkg::MUL_W-1:0]   n_q1_prod;

    logic                               r_q1_vld;
    pdw_pkg::t_mid                      r_q1_mid;
    logic signed [pdw_pkg::RES_W-1:0]   r_q1_res;
    logic signed [pdw_pkg::MUL_W-1:0]   r_q1_prod;

    logic signed [pdw_pkg::MUL_W-1:0]   prod_sh;
    logic signed [pdw_pkg::Y_W-1:0]     y;
    logic [pdw_pkg::Y_W-1:0]            ny;
    logic [pdw_pkg::Y_W:0]              ysum;
    logic [pdw_pkg::Y_W-pdw_pkg::FB:0]  s;
    logic [pdw_pkg::FB:0]               pval;
    logic signed [pdw_pkg::RES_W-1:0]   res;
    logic [pdw_pkg::FB:0]               n_q2_resc;

    logic                               r_q2_vld;
    logic                               r_q2_bypass;
    logic [pdw_pkg::POS_W-1:0]          r_q2_pos;
    logic [pdw_pkg::POS_W-1:0]          r_q2_ws;
    logic [pdw_pkg::POS_W-1:0]          r_q2_len;
    logic [pdw_pkg::FB:0]               r_q2_resc;

    logic                               r_q3_vld;
    logic                               r_q3_bypass;
    logic [pdw_pkg::POS_W-1:0]          r_q3_pos;
    logic [pdw_pkg::POS_W-1:0]          r_q3_ws;
    logic [pdw_pkg::FB+pdw_pkg::POS_W:0] r_q3_prod;

    logic [pdw_pkg::POS_W-1:0]          n_q4_out;
    logic                               r_q4_vld;
    logic [pdw_pkg::POS_W-1:0]          r_q4_out;

    always_comb begin
        qv       = $signed({1'b0, i_quot[pdw_pkg::RES_W-2:0]});
        n_q1_res = $signed({{(pdw_pkg::RES_W-pdw_pkg::PC_W){i_mid.base[pdw_pkg::PC_W-1]}},
                            i_mid.base})
                 + (i_mid.negq ? -qv : qv);
        b14 = i_mid.dneg ? i_quot[pdw_pkg::E14_W-1:0] : i_mid.e14;
        if (i_mid.mode == pdw_pkg::MODE_DSINE) begin
            op_a = i_mid.diff4;
            op_b = $signed({{(pdw_pkg::E14_W+2-pdw_pkg::AMT_W){1'b0}}, i_mid.amt});
        end else begin
            op_a = $signed({{(pdw_pkg::P4_W+1-pdw_pkg::LG_W){i_mid.lg[pdw_pkg::LG_W-1]}},
                            i_mid.lg});
            op_b = $signed({1'b0, b14});
        end
        n_q1_prod = pdw_pkg::MUL_W'(op_a) * pdw_pkg::MUL_W'(op_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_vld <= 1'b0;
        end else begin
            r_q1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q1_mid  <= i_mid;
        r_q1_res  <= n_q1_res;
        r_q1_prod <= n_q1_prod;
    end

    always_comb begin
        prod_sh = r_q1_prod >>> pdw_pkg::AMT_FRAC;
        y       = prod_sh[pdw_pkg::Y_W-1:0];
        ny      = -y;
        ysum    = {1'b0, ny} + pdw_pkg::Y_FMASK;
        s       = ysum[pdw_pkg::Y_W:pdw_pkg::FB];
        pval    = {1'b1, y[pdw_pkg::FB-1:0]} >> s;
        unique case (r_q1_mid.mode) inside
            pdw_pkg::MODE_DSINE: begin
                res = $signed({{(pdw_pkg::RES_W-pdw_pkg::P4_W){r_q1_mid.p4[pdw_pkg::P4_W-1]}},
                               r_q1_mid.p4})
                    + $signed(prod_sh[pdw_pkg::RES_W-1:0]);
            end
            pdw_pkg::MODE_POW4, pdw_pkg::MODE_POW8: begin
                if (!r_q1_mid.pc_pos) begin
                    res = '0;
                end else if (!y[pdw_pkg::Y_W-1]) begin
                    res = pdw_pkg::RES_ONE;
                end else begin
                    res = $signed({{(pdw_pkg::RES_W-pdw_pkg::FB-1){1'b0}}, pval});
                end
            end
            default: begin
                res = r_q1_res;
            end
        endcase
        if (res[pdw_pkg::RES_W-1]) begin
            n_q2_resc = '0;
        end else if (res > pdw_pkg::RES_ONE) begin
            n_q2_resc = pdw_pkg::RES_ONE[pdw_pkg::FB:0];
        end else begin
            n_q2_resc = res[pdw_pkg::FB:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q2_vld <= 1'b0;
            r_q3_vld <= 1'b0;
            r_q4_vld <= 1'b0;
        end else begin
            r_q2_vld <= r_q1_vld;
            r_q3_vld <= r_q2_vld;
            r_q4_vld <= r_q3_vld;
        end
    end

    assign n_q4_out = r_q3_bypass ? r_q3_pos
                    : pdw_pkg::POS_W'({1'b0, r_q3_ws}
                                      + r_q3_prod[pdw_pkg::FB+pdw_pkg::POS_W:pdw_pkg::FB]);

    always_ff @(posedge i_clk) begin
        r_q2_bypass <= r_q1_mid.bypass;
        r_q2_pos    <= r_q1_mid.pos;
        r_q2_ws     <= r_q1_mid.ws;
        r_q2_len    <= r_q1_mid.len;
        r_q2_resc   <= n_q2_resc;
        r_q3_bypass <= r_q2_bypass;
        r_q3_pos    <= r_q2_pos;
        r_q3_ws     <= r_q2_ws;
        r_q3_prod   <= (pdw_pkg::FB+pdw_pkg::POS_W+1)'(r_q2_resc)
                     * (pdw_pkg::FB+pdw_pkg::POS_W+1)'(r_q2_len);
        r_q4_out    <= n_q4_out;
    end

    assign o_valid           = r_q4_vld;
    assign o_warped_position = r_q4_out;

endmodule

// ===== verif/phase_distortion_warp_checker.sv =====
// ----------------------------------------------------------------------------
// phase_distortion_warp_checker: prediction and comparison for the warp
// Watches the command and result channels of the block, computes the warped
// position of every accepted transaction in a fixed-point model of its own,
// and compares each strobed result with the oldest prediction in order.
// ----------------------------------------------------------------------------
module phase_distortion_warp_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_busy,
    input  logic [pdw_pkg::MODE_W-1:0]       i_mode,
    input  logic [pdw_pkg::POS_W-1:0]        i_position,
    input  logic signed [pdw_pkg::AMT_W-1:0] i_amount,
    input  logic [pdw_pkg::POS_W-1:0]        i_window_start,
    input  logic [pdw_pkg::POS_W-1:0]        i_window_end,
    input  logic                             i_valid,
    input  logic [pdw_pkg::POS_W-1:0]        i_warped_position,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FB    = pdw_pkg::FB;
    localparam int     POS_W = pdw_pkg::POS_W;
    localparam int     AMT_W = pdw_pkg::AMT_W;
    localparam longint FONE  = longint'(1) << FB;
    localparam longint FHALF = longint'(1) << (FB - 1);
    localparam longint FMSK  = FONE - 1;
    localparam longint K_499 = ((longint'(499) << FB) + 500) / 1000;
    localparam longint A_ONE = 16384;

    logic [POS_W-1:0] warped_queue[$];

    function automatic longint mul_floor(longint a, longint b, int s);
        longint p;
        p = a * b;
        return p >>> s;
    endfunction

    function automatic longint div_trunc(longint num, longint den);
        if (den <= 0) return 0;
        return num / den;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint mitchell_power(longint x, longint b14);
        int k;
        longint frac;
        longint lg;
        longint y;
        longint unsigned s;
        k = 0;
        if (x <= 0) return 0;
        while (k < 62 && (x >>> (k + 1)) != 0) k++;
        if (k <= FB) frac = (x << (FB - k)) - FONE;
        else frac = (x >>> (k - FB)) - FONE;
        lg = longint'(k - FB) * FONE + frac;
        y = mul_floor(lg, b14, 14);
        if (y >= 0) return FONE;
        s = (longint'(-y) + FMSK) >> FB;
        if (s >= 62) return 0;
        return (FONE + (y & FMSK)) >>> s;
    endfunction

    function automatic logic [POS_W-1:0] predict_warp(
        pdw_pkg::t_mode mode, logic [POS_W-1:0] pos, logic signed [AMT_W-1:0] amount,
        logic [POS_W-1:0] ws, logic [POS_W-1:0] we);
        longint unsigned len;
        longint unsigned mag;
        longint unsigned m;
        longint ph, pc, res, d, amt, hd, bp, den, e14, b14, fr, dbl, tgt, p4;
        bit neg;
        if (mode == pdw_pkg::MODE_PASS || we <= ws) return pos;
        len = 64'(we - ws);
        neg = pos < ws;
        mag = 64'(neg ? ws - pos : pos - ws);
        mag = (mag << FB) / len;
        ph = neg ? -longint'(mag) : longint'(mag);
        d = clip(longint'(amount), -A_ONE, A_ONE);
        amt = d < 0 ? -d : d;
        pc = clip(ph, -2 * FONE, 2 * FONE);
        hd = mul_floor(K_499, d, 14);
        case (mode)
            pdw_pkg::MODE_PULSE: begin
                bp = FHALF + hd;
                if (pc < bp) res = div_trunc(pc * FHALF, bp);
                else res = FHALF + div_trunc((pc - bp) * FHALF, FONE - bp);
            end
            pdw_pkg::MODE_SQUARE: begin
                den = FHALF - hd;
                if (pc < FHALF) res = div_trunc(pc * FHALF, den);
                else res = FONE - div_trunc((FONE - pc) * FHALF, den);
            end
            pdw_pkg::MODE_TRIANGLE: begin
                den = FHALF - hd;
                if (pc < FHALF) res = div_trunc(pc * FHALF, den);
                else res = FHALF + div_trunc((pc - FHALF) * FHALF, den);
            end
            pdw_pkg::MODE_DSINE: begin
                m = ph < 0 ? longint'(-ph) : longint'(ph);
                fr = longint'((m << 1) & FMSK);
                dbl = ph < 0 ? -fr : fr;
                tgt = d < 0 ? FONE - dbl : dbl;
                p4 = clip(ph, -(longint'(1) << 15) * FONE, (longint'(1) << 15) * FONE);
                res = p4 + mul_floor(amt, tgt - p4, 14);
            end
            pdw_pkg::MODE_SAWTRI: begin
                if (pc < FHALF) res = div_trunc(pc * FHALF, FHALF - hd);
                else res = FHALF + div_trunc((pc - FHALF) * FHALF, FHALF + hd);
            end
            default: begin
                e14 = A_ONE + (mode == pdw_pkg::MODE_POW4 ? 4 : 8) * amt;
                b14 = d < 0 ? (A_ONE * A_ONE + e14 / 2) / e14 : e14;
                res = mitchell_power(pc, b14);
            end
        endcase
        res = clip(res, 0, FONE);
        return POS_W'(longint'(ws) + ((longint'(res) * longint'(len)) >>> FB));
    endfunction

    assign o_pending = warped_queue.size();

    always @(posedge i_clk) begin
        logic [POS_W-1:0] want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_checked <= 0;
        end else begin
            if (i_start && !i_busy) begin
                warped_queue.push_back(predict_warp(pdw_pkg::t_mode'(i_mode), i_position,
                    i_amount, i_window_start, i_window_end));
            end
            if (i_valid) begin
                if (warped_queue.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("Unexpected result transaction: warped_position %h",
                            i_warped_position);
                    end
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = warped_queue.pop_front();
                    o_checked <= o_checked + 1;
                    if (want !== i_warped_position) begin
                        if (o_fail_count < 10) begin
                            $display("Mismatch: warped_position expected %h actual %h",
                                want, i_warped_position);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== verif/phase_distortion_warp_test.sv =====
// ----------------------------------------------------------------------------
// phase_distortion_warp_test: top of the phase distortion warp testbench
// Drives directed corner transactions and then random windows, positions,
// amounts and modes under three sender idling patterns, and reports the
// verdict from the failure and pending counts of the checker.
// ----------------------------------------------------------------------------
module phase_distortion_warp_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MODE_W  = pdw_pkg::MODE_W;
    localparam int POS_W   = pdw_pkg::POS_W;
    localparam int AMT_W   = pdw_pkg::AMT_W;
    localparam int LATENCY = pdw_pkg::LATENCY;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [MODE_W-1:0]       i_mode = '0;
    logic [POS_W-1:0]        i_position = '0;
    logic signed [AMT_W-1:0] i_amount = '0;
    logic [POS_W-1:0]        i_window_start = '0;
    logic [POS_W-1:0]        i_window_end = '0;
    logic                    o_valid;
    logic [POS_W-1:0]        o_warped_position;
    int                      fail_count;
    int                      pending;
    int                      checked;
    int                      idle_pct = 0;
    int                      wait_cycles;

    always #5 i_clk = ~i_clk;

    phase_distortion_warp u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_position(i_position), .i_amount(i_amount),
        .i_window_start(i_window_start), .i_window_end(i_window_end),
        .o_valid(o_valid), .o_warped_position(o_warped_position)
    );

    phase_distortion_warp_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_mode(i_mode), .i_position(i_position), .i_amount(i_amount),
        .i_window_start(i_window_start), .i_window_end(i_window_end),
        .i_valid(o_valid), .i_warped_position(o_warped_position),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    task automatic send_warp(pdw_pkg::t_mode mode, logic [POS_W-1:0] pos,
                             logic signed [AMT_W-1:0] amount,
                             logic [POS_W-1:0] ws, logic [POS_W-1:0] we);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_mode <= mode;
        i_position <= pos;
        i_amount <= amount;
        i_window_start <= ws;
        i_window_end <= we;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send_random();
        logic [POS_W-1:0] ws, we, len, pos;
        logic signed [AMT_W-1:0] amount;
        int pick;
        ws = $urandom();
        pick = $urandom_range(99);
        if (pick < 40) len = $urandom_range(1, 16'hFFFF);
        else if (pick < 55) len = $urandom_range(1, 16);
        else len = $urandom();
        if (len == 0) len = 1;
        if (ws > ~len) ws = ~len;
        we = ws + len;
        pick = $urandom_range(99);
        if (pick < 5) we = ws;
        else if (pick < 10) begin
            we = ws;
            ws = $urandom();
        end
        pick = $urandom_range(99);
        if (pick < 70 && len != 0) pos = ws + ($urandom() % len);
        else if (pick < 85) pos = ws + $urandom_range(0, 2 * len) - len / 2;
        else pos = $urandom();
        pick = $urandom_range(99);
        if (pick < 85) amount = AMT_W'($signed($urandom_range(0, 32768)) - 16384);
        else amount = AMT_W'($urandom());
        send_warp(pdw_pkg::t_mode'($urandom_range(7)), pos, amount, ws, we);
    endtask

    initial begin
        #(5ms);
        $display("Timeout while waiting for result transactions.");
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_warp(pdw_pkg::MODE_PASS, 32'hFFFF_FFFF, 16'sd8000, 32'h0, 32'hFFFF_FFFF);
        send_warp(pdw_pkg::MODE_PULSE, 32'h0001_0000, 16'sd8000,
                  32'h0002_0000, 32'h0002_0000);
        send_warp(pdw_pkg::MODE_SQUARE, 32'h0001_0000, 16'sd8000,
                  32'h0003_0000, 32'h0002_0000);
        for (int m = 1; m < 8; m++) begin
            send_warp(pdw_pkg::t_mode'(m), 32'h0001_4000, 16'sd16384,
                      32'h0001_0000, 32'h0002_0000);
            send_warp(pdw_pkg::t_mode'(m), 32'h0001_C000, -16'sd16384,
                      32'h0001_0000, 32'h0002_0000);
        end
        send_warp(pdw_pkg::MODE_TRIANGLE, 32'h0000_0000, 16'sh8000,
                  32'h8000_0000, 32'hFFFF_FFFF);
        send_warp(pdw_pkg::MODE_SAWTRI, 32'hFFFF_FFFF, 16'sd32767,
                  32'h0000_0000, 32'h0000_0001);
        send_warp(pdw_pkg::MODE_DSINE, 32'h0000_0000, -16'sd9000,
                  32'hFFFF_0000, 32'hFFFF_FFFF);
        send_warp(pdw_pkg::MODE_DSINE, 32'h0000_8000, 16'sd9000,
                  32'h0001_0000, 32'h0002_0000);
        send_warp(pdw_pkg::MODE_POW4, 32'h0000_8000, 16'sd4000,
                  32'h0001_0000, 32'h0002_0000);
        send_warp(pdw_pkg::MODE_POW8, 32'h0001_0000, -16'sd4000,
                  32'h0001_0000, 32'h0002_0000);
        send_warp(pdw_pkg::MODE_POW8, 32'h0001_FFFF, 16'sd0,
                  32'h0001_0000, 32'h0002_0000);
        send_warp(pdw_pkg::MODE_PULSE, 32'h0001_8000, 16'sd0,
                  32'h0001_0000, 32'h0002_0000);

        idle_pct = 15;
        repeat (533) send_random();
        idle_pct = 75;
        repeat (533) send_random();
        idle_pct = 0;
        repeat (534) send_random();
        start <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 4 * LATENCY) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Covered all eight modes, empty and inverted windows, clamped amounts");
        $display("and far-outside phases; %0d results checked.", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pdw_pkg.sv
rtl/pdw_div.sv
rtl/pdw_prep.sv
rtl/pdw_post.sv
rtl/phase_distortion_warp.sv
verif/phase_distortion_warp_checker.sv
verif/phase_distortion_warp_test.sv
